>>> rtl/ekv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ekv_pkg: shared types and constants for the expiring key-value table
// Payload structs for both channels, the stored entry layout, the command
// and status codes and the sequencer states.
// ----------------------------------------------------------------------------
package ekv_pkg;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic signed [31:0] expiry_time;
    } ekv_in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               status;
    } ekv_out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] expiry;
        logic [31:0] value;
    } ekv_entry_t;

    localparam int ENTRY_W = $bits(ekv_entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } ekv_state_t;

endpackage
`default_nettype wire

>>> rtl/ekv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ekv_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ekv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire                      re,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/ekv_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ekv_engine: table sequencer and scan datapath
// Walks every slot once per command: reads the entry, sweeps it if its
// expiry equals the next count, tracks key match and first free slot, then
// writes the set entry if a slot is found and presents one result.
// ----------------------------------------------------------------------------
module ekv_engine #(
    parameter int CAPACITY = 64
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              cmd_valid,
    output logic             cmd_ready,
    input  wire ekv_pkg::ekv_in_t cmd,
    output logic             res_valid,
    input  wire              res_ready,
    output ekv_pkg::ekv_out_t res
);
    import ekv_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = AW + 1;

    ekv_state_t state_reg, state_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             chk_vld_reg;
    logic [AW-1:0]    chk_addr_reg;
    logic [31:0]      op_count_reg;
    logic [31:0]      next_count;

    ekv_in_t          cmd_reg;
    logic             match_reg, match_next;
    logic [AW-1:0]    match_slot_reg, match_slot_next;
    logic             free_reg, free_next;
    logic [AW-1:0]    free_slot_reg, free_slot_next;
    logic [31:0]      val_reg, val_next;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    ekv_entry_t       ram_wdata, ram_rdata;
    logic             sweep, key_eq, scan_end;

    ekv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign next_count = op_count_reg + 32'd1;
    assign scan_end   = (idx_reg == CNT_W'(CAPACITY));
    assign sweep      = chk_vld_reg && ram_rdata.valid && (ram_rdata.expiry == next_count);
    assign key_eq     = chk_vld_reg && ram_rdata.valid && (ram_rdata.key == cmd_reg.key);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (scan_end) state_next = ST_IDLE;
            ST_IDLE:  if (cmd_valid) state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = (cmd_reg.command == CMD_SET) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // scan bookkeeping
    always_comb begin
        idx_next        = idx_reg;
        match_next      = match_reg;
        match_slot_next = match_slot_reg;
        free_next       = free_reg;
        free_slot_next  = free_slot_reg;
        val_next        = val_reg;
        if (state_reg == ST_CLEAR || state_reg == ST_SCAN) begin
            idx_next = scan_end ? idx_reg : idx_reg + CNT_W'(1);
        end
        if (state_reg == ST_IDLE) begin
            idx_next   = '0;
            match_next = 1'b0;
            free_next  = 1'b0;
        end
        if (state_reg == ST_SCAN && chk_vld_reg) begin
            if (cmd_reg.command == CMD_SET) begin
                // set looks at the table before this command's sweep
                if (key_eq && !match_reg) begin
                    match_next      = 1'b1;
                    match_slot_next = chk_addr_reg;
                end
                if (!ram_rdata.valid && !free_reg) begin
                    free_next      = 1'b1;
                    free_slot_next = chk_addr_reg;
                end
            end else if (key_eq && !sweep && !match_reg) begin
                match_next = 1'b1;
                val_next   = ram_rdata.value;
            end
        end
    end

    // memory port control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = idx_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = chk_addr_reg;
        ram_wdata = ram_rdata;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = !scan_end;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = '0;
            end
            ST_SCAN: begin
                ram_re = !scan_end;
                // drop entries that expire at the next count
                if (sweep) begin
                    ram_we          = 1'b1;
                    ram_wdata.valid = 1'b0;
                end
            end
            ST_WRITE: begin
                ram_we           = match_reg || free_reg;
                ram_waddr        = match_reg ? match_slot_reg : free_slot_reg;
                ram_wdata.valid  = (cmd_reg.expiry_time != next_count);
                ram_wdata.key    = cmd_reg.key;
                ram_wdata.expiry = cmd_reg.expiry_time;
                ram_wdata.value  = cmd_reg.value;
            end
            ST_IDLE, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // handshake and result
    always_comb begin
        cmd_ready      = (state_reg == ST_IDLE);
        res_valid      = (state_reg == ST_DONE);
        res.hit        = (cmd_reg.command == CMD_GET) && match_reg;
        res.read_value = res.hit ? signed'(val_reg) : '0;
        res.status     = (cmd_reg.command == CMD_SET && !match_reg && !free_reg)
                         ? STATUS_FULL : STATUS_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            op_count_reg <= '0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= ram_re;
            match_reg   <= match_next;
            free_reg    <= free_next;
            if (res_valid && res_ready) begin
                op_count_reg <= next_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chk_addr_reg   <= idx_reg[AW-1:0];
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
        val_reg        <= val_next;
        if (cmd_valid && cmd_ready) begin
            cmd_reg <= cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("write-back and read hit the same slot");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> (op_count_reg == $past(op_count_reg) + 32'd1))
        else $error("operation count did not advance by one");

    a_hit_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.hit && res.status == STATUS_FULL))
        else $error("result flags both hit and table full");

    a_scan_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_vld_reg |-> (state_reg == ST_SCAN))
        else $error("read data returned outside a scan");
`endif

endmodule
`default_nettype wire

>>> rtl/expiring_key_value_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// expiring_key_value_table: key-value table with entries that expire by count
// Input channel s_valid/s_ready/s_data carries set or get commands; output
// channel m_valid/m_ready/m_data returns exactly one result per command.
// Every command walks all CAPACITY slots of the entry RAM once, one slot
// per cycle through its single read port, removing entries whose expiry
// equals the new operation count and matching the key.
// One command is in work at a time; the next is taken once the result has
// moved into the output register.
// After reset the RAM is cleared one slot a cycle; s_ready stays low until
// the clear is done. The output register holds a result while m_ready is
// low; the block can accept and work on the next command meanwhile, and
// waits with its own result until the register frees.
// ----------------------------------------------------------------------------
module expiring_key_value_table #(
    parameter int CAPACITY = 64
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire ekv_pkg::ekv_in_t s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output ekv_pkg::ekv_out_t m_data
);
    import ekv_pkg::*;

    logic     res_valid, res_ready;
    ekv_out_t res;
    logic     m_valid_reg;
    ekv_out_t m_data_reg;

    ekv_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // take a new result when the register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_busy_after_reset: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !s_ready)
        else $error("input taken before the table was cleared");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !res_ready)
        else $error("pending result would be overwritten");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_valid)
        else $error("result transfer did not reach the output register");
`endif

endmodule
`default_nettype wire
